>>> src/positional_unique_array_list_defines.svh
// Assertion macros for the positional unique array list.
// Included by the top level, which checks its own logic; no other dependencies.
`ifndef POSITIONAL_UNIQUE_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_UNIQUE_ARRAY_LIST_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PUAL_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PUAL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PUAL_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PUAL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> src/pual_pkg.sv
// Shared types, codes and elaboration helpers for the positional unique array list.
// Has no dependencies; every other RTL file refers to it by scoped names.
package pual_pkg;

   localparam int unsigned DEPTH_DEFAULT  = 64;
   localparam int unsigned CAP_RESET      = 64;
   localparam int unsigned POS_W          = 7;
   localparam int unsigned DATA_W         = 32;
   localparam int unsigned CAP_W          = 7;
   localparam int unsigned LEN_W          = 7;
   localparam int unsigned TREE_RADIX_LOG = 3;

   typedef enum logic [2:0] {
      ACT_INSERT = 3'd0,
      ACT_REMOVE = 3'd1,
      ACT_WRITE  = 3'd2,
      ACT_READ   = 3'd3,
      ACT_NEXT   = 3'd4,
      ACT_BACK   = 3'd5,
      ACT_CLEAR  = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      STAT_OK     = 3'd0,
      STAT_FULL   = 3'd1,
      STAT_BADPOS = 3'd2,
      STAT_DUP    = 3'd3,
      STAT_EMPTY  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_WRITE  = 2'd3
   } cell_op_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_CHECK = 3'd1,
      S_EXEC  = 3'd2,
      S_READ  = 3'd3,
      S_DONE  = 3'd4
   } state_type;

   typedef struct packed {
      action_type         action;
      logic [POS_W-1:0]   position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [DATA_W-1:0] cursor_data;
      logic               cursor_data_valid;
      logic [LEN_W-1:0]   length;
      logic               is_full;
      logic               is_empty;
   } rsp_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      cell_op_type        op;
      logic [POS_W-1:0]   position;
      logic [DATA_W-1:0]  value;
   } cell_ctrl_type;

   // Number of nodes on level l of a radix-8 reduction tree over n leaves.
   function automatic int unsigned level_size(int unsigned n, int unsigned l);
      return (n + (1 << (TREE_RADIX_LOG * l)) - 1) >> (TREE_RADIX_LOG * l);
   endfunction

   // Registered levels needed to bring n leaves down to one root.
   function automatic int unsigned tree_levels(int unsigned n);
      int unsigned l;
      l = 1;
      while (level_size(n, l) > 1) begin
         l++;
      end
      return l;
   endfunction

   // Start of level l in a flat array that holds levels 1 and up.
   function automatic int unsigned level_offset(int unsigned n, int unsigned l);
      int unsigned off;
      off = 0;
      for (int unsigned k = 1; k < l; k++) begin
         off += level_size(n, k);
      end
      return off;
   endfunction

endpackage

>>> src/pual_cell.sv
// One storage cell of the list chain: holds a single entry and trades it with its neighbors.
// Depends on pual_pkg for the control struct and op codes.
module pual_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned IDX_W = 6,
   parameter int unsigned CNT_W = 7,
   parameter int unsigned CW    = 7
) (
   input  logic                              clock,
   input  pual_pkg::cell_ctrl_type           ctrl,
   input  logic [CNT_W-1:0]                  count,
   input  logic [IDX_W-1:0]                  cursor_index,
   input  logic                              cursor_valid,
   input  logic [pual_pkg::DATA_W-1:0]       left_data,
   input  logic [pual_pkg::DATA_W-1:0]       right_data,
   output logic [pual_pkg::DATA_W-1:0]       data,
   output logic [pual_pkg::DATA_W:0]         contrib
);

   logic [pual_pkg::DATA_W-1:0] data_ff;
   logic [pual_pkg::DATA_W-1:0] data_in;
   logic [CW-1:0]               me;
   logic [CW-1:0]               pos;
   logic                        occupied;
   logic                        at_cursor;

   assign me        = CW'(INDEX);
   assign pos       = CW'(ctrl.position);
   assign occupied  = me < CW'(count);
   assign at_cursor = cursor_valid && (cursor_index == IDX_W'(INDEX)) && occupied;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         pual_pkg::CELL_INSERT: begin
            if (me > pos) begin
               data_in = left_data;
            end else if (me == pos) begin
               data_in = ctrl.value;
            end
         end
         pual_pkg::CELL_REMOVE: begin
            if (me >= pos) begin
               data_in = right_data;
            end
         end
         pual_pkg::CELL_WRITE: begin
            if (me == pos) begin
               data_in = ctrl.value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   // Top bit flags a stored copy of the broadcast value; the rest carries the
   // entry only when the cursor sits here, so an OR over all cells selects it.
   assign contrib = {occupied && (data_ff == ctrl.value),
                     at_cursor ? data_ff : {pual_pkg::DATA_W{1'b0}}};

endmodule

>>> src/pual_reduce.sv
// Registered radix-8 OR tree that folds the per-cell flags and cursor data to one word.
// Depends on pual_pkg for the tree sizing functions.
module pual_reduce #(
   parameter int unsigned N = 64,
   parameter int unsigned W = 33
) (
   input  logic         clock,
   input  logic [W-1:0] leaves [N],
   output logic [W-1:0] root
);

   localparam int unsigned RADIX = 1 << pual_pkg::TREE_RADIX_LOG;
   localparam int unsigned LV    = pual_pkg::tree_levels(N);
   localparam int unsigned TOTAL = pual_pkg::level_offset(N, LV + 1);

   logic [W-1:0] node_ff [TOTAL];

   for (genvar l = 1; l <= LV; l++) begin : g_level
      localparam int unsigned NODES = pual_pkg::level_size(N, l);
      localparam int unsigned PREV  = pual_pkg::level_size(N, l - 1);
      localparam int unsigned NOFF  = pual_pkg::level_offset(N, l);
      for (genvar j = 0; j < NODES; j++) begin : g_node
         logic [W-1:0] kids [RADIX];
         logic [W-1:0] sum_or;
         for (genvar c = 0; c < RADIX; c++) begin : g_kid
            if (j * RADIX + c >= PREV) begin : g_pad
               assign kids[c] = '0;
            end else if (l == 1) begin : g_leaf
               assign kids[c] = leaves[j * RADIX + c];
            end else begin : g_inner
               assign kids[c] = node_ff[pual_pkg::level_offset(N, l - 1) + j * RADIX + c];
            end
         end
         always_comb begin
            sum_or = '0;
            for (int k = 0; k < RADIX; k++) begin
               sum_or |= kids[k];
            end
         end
         always_ff @(posedge clock) begin
            node_ff[NOFF + j] <= sum_or;
         end
      end
   end

   assign root = node_ff[TOTAL - 1];

endmodule

>>> src/positional_unique_array_list.sv
// Top level of the positional unique array list: controller, cell chain and OR tree.
// Depends on pual_pkg, pual_cell, pual_reduce and the assertion macro header.
//
//   channel   ports                                   direction  handshake
//   request   req_valid  req_ready  req_payload       in         valid/ready
//   response  rsp_valid  rsp_ready  rsp_payload       out        valid/ready
//   config    csr_write_enable  csr_write_data        in         write enable
//
// A request passes through the check, execute, read and done states; the check and
// read phases each wait on the LV registered levels of the OR tree (ceil of log8
// DEPTH, 2 levels at DEPTH 64), and the response register is loaded in the done state.
// The tree is walked twice per request: once for the duplicate search and once
// to read the entry under the cursor after the action has been applied.
// Reset is synchronous and active high; it empties the list, drops the cursor
// and sets the capacity to 64. Entry contents are not reset.
// A response waiting on rsp_ready does not block the next request; the block
// stalls only when a second response is finished while the first still waits.
`include "positional_unique_array_list_defines.svh"

module positional_unique_array_list #(
   parameter int unsigned DEPTH = pual_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pual_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pual_pkg::rsp_type             rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [pual_pkg::CAP_W-1:0]    csr_write_data
);

   localparam int unsigned IDX_W  = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned CW     = (CNT_W > pual_pkg::POS_W) ? CNT_W : pual_pkg::POS_W;
   localparam int unsigned LV     = pual_pkg::tree_levels(DEPTH);
   localparam int unsigned WAIT_W = (LV > 1) ? $clog2(LV) : 1;
   localparam int unsigned LEAF_W = pual_pkg::DATA_W + 1;

   // Sequencer and request holding registers.
   pual_pkg::state_type         state_ff, state_in;
   logic [WAIT_W-1:0]           wait_ff, wait_in;
   pual_pkg::req_type           req_ff;

   // List bookkeeping. The entries themselves live in the cells.
   logic [pual_pkg::CAP_W-1:0]  capacity_ff;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [IDX_W-1:0]            cursor_index_ff, cursor_index_in;
   logic                        cursor_valid_ff, cursor_valid_in;
   pual_pkg::status_type        status_ff, status_in;

   // Response register that decouples the block from the consumer.
   pual_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        wait_done;
   logic                        exec_en;
   logic                        rsp_load;
   pual_pkg::cell_op_type       exec_op;
   pual_pkg::cell_ctrl_type     cell_ctrl;

   logic [CW-1:0]               count_w;
   logic [CW-1:0]               count_dec;
   logic [CW-1:0]               pos_w;
   logic [CW-1:0]               cursor_w;
   logic [CW-1:0]               cap_eff;
   logic                        list_full;
   logic                        dup_found;

   logic [pual_pkg::DATA_W-1:0] cell_data [DEPTH];
   logic [LEAF_W-1:0]           contrib [DEPTH];
   logic [LEAF_W-1:0]           root;

   assign count_w   = CW'(count_ff);
   assign count_dec = count_w - CW'(1);
   assign pos_w     = CW'(req_ff.position);
   assign cursor_w  = CW'(cursor_index_ff);
   // A capacity above the chain length is limited to the chain length; zero
   // keeps the list permanently full.
   assign cap_eff   = (CW'(capacity_ff) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity_ff);
   assign list_full = count_w >= cap_eff;
   // After the check phase the tree root carries the OR of all match flags.
   assign dup_found = root[pual_pkg::DATA_W];
   assign wait_done = wait_ff == WAIT_W'(LV - 1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pual_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = pual_pkg::S_CHECK;
            end
         end
         pual_pkg::S_CHECK: begin
            if (wait_done) begin
               state_in = pual_pkg::S_EXEC;
            end
         end
         pual_pkg::S_EXEC: begin
            state_in = pual_pkg::S_READ;
         end
         pual_pkg::S_READ: begin
            if (wait_done) begin
               state_in = pual_pkg::S_DONE;
            end
         end
         pual_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = pual_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pual_pkg::S_IDLE;
         end
      endcase
   end

   // Sequencer outputs. No request is taken while reset is held.
   always_comb begin
      req_ready = 1'b0;
      exec_en   = 1'b0;
      rsp_load  = 1'b0;
      wait_in   = '0;
      case (state_ff)
         pual_pkg::S_IDLE: begin
            req_ready = !reset;
         end
         pual_pkg::S_CHECK, pual_pkg::S_READ: begin
            wait_in = wait_done ? '0 : wait_ff + WAIT_W'(1);
         end
         pual_pkg::S_EXEC: begin
            exec_en = 1'b1;
         end
         pual_pkg::S_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   // Action decode: decides the outcome and what the cells do in the
   // execute cycle. Checks follow the priority the list defines per action.
   always_comb begin
      status_in       = pual_pkg::STAT_OK;
      exec_op         = pual_pkg::CELL_HOLD;
      count_in        = count_ff;
      cursor_index_in = cursor_index_ff;
      cursor_valid_in = cursor_valid_ff;
      case (req_ff.action)
         pual_pkg::ACT_INSERT: begin
            if (list_full) begin
               status_in = pual_pkg::STAT_FULL;
            end else if (pos_w > count_w) begin
               status_in = pual_pkg::STAT_BADPOS;
            end else if (dup_found) begin
               status_in = pual_pkg::STAT_DUP;
            end else begin
               exec_op         = pual_pkg::CELL_INSERT;
               count_in        = CNT_W'(count_w + CW'(1));
               cursor_index_in = IDX_W'(pos_w);
               cursor_valid_in = 1'b1;
            end
         end
         pual_pkg::ACT_REMOVE: begin
            if (count_ff == '0) begin
               status_in = pual_pkg::STAT_EMPTY;
            end else if (pos_w >= count_w) begin
               status_in = pual_pkg::STAT_BADPOS;
            end else begin
               exec_op  = pual_pkg::CELL_REMOVE;
               count_in = CNT_W'(count_dec);
               // The cursor follows the tail when the tail moves under it.
               if (count_dec == '0) begin
                  cursor_valid_in = 1'b0;
               end else if (cursor_valid_ff && (cursor_w >= count_dec)) begin
                  cursor_index_in = IDX_W'(count_dec - CW'(1));
               end
            end
         end
         pual_pkg::ACT_WRITE: begin
            if (pos_w >= count_w) begin
               status_in = pual_pkg::STAT_BADPOS;
            end else begin
               exec_op         = pual_pkg::CELL_WRITE;
               cursor_index_in = IDX_W'(pos_w);
               cursor_valid_in = 1'b1;
            end
         end
         pual_pkg::ACT_READ: begin
            if (!cursor_valid_ff) begin
               status_in = pual_pkg::STAT_EMPTY;
            end
         end
         pual_pkg::ACT_NEXT: begin
            if (!cursor_valid_ff) begin
               status_in = pual_pkg::STAT_EMPTY;
            end else if (cursor_w + CW'(1) < count_w) begin
               cursor_index_in = cursor_index_ff + IDX_W'(1);
            end
         end
         pual_pkg::ACT_BACK: begin
            if (!cursor_valid_ff) begin
               status_in = pual_pkg::STAT_EMPTY;
            end else if (cursor_index_ff != '0) begin
               cursor_index_in = cursor_index_ff - IDX_W'(1);
            end
         end
         pual_pkg::ACT_CLEAR: begin
            count_in        = '0;
            cursor_index_in = '0;
            cursor_valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Response assembly from the state left by the action. The cursor entry
   // comes off the tree root after the read phase.
   always_comb begin
      rsp_in.status            = status_ff;
      rsp_in.cursor_data       = root[pual_pkg::DATA_W-1:0];
      rsp_in.cursor_data_valid = cursor_valid_ff && (cursor_w < count_w);
      rsp_in.length            = pual_pkg::LEN_W'(count_ff);
      rsp_in.is_full           = list_full;
      rsp_in.is_empty          = count_ff == '0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= pual_pkg::S_IDLE;
         wait_ff         <= '0;
         capacity_ff     <= pual_pkg::CAP_W'(pual_pkg::CAP_RESET);
         count_ff        <= '0;
         cursor_index_ff <= '0;
         cursor_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if (exec_en) begin
            count_ff        <= count_in;
            cursor_index_ff <= cursor_index_in;
            cursor_valid_ff <= cursor_valid_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
      if (exec_en) begin
         status_ff <= status_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // The broadcast value and position stay on the chain for the whole request;
   // only the execute cycle lets the cells change.
   assign cell_ctrl.op       = exec_en ? exec_op : pual_pkg::CELL_HOLD;
   assign cell_ctrl.position = req_ff.position;
   assign cell_ctrl.value    = req_ff.value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [pual_pkg::DATA_W-1:0] left_data;
      logic [pual_pkg::DATA_W-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i - 1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i + 1];
      end
      pual_cell #(
         .INDEX (i),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W),
         .CW    (CW)
      ) u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl),
         .count        (count_ff),
         .cursor_index (cursor_index_ff),
         .cursor_valid (cursor_valid_ff),
         .left_data    (left_data),
         .right_data   (right_data),
         .data         (cell_data[i]),
         .contrib      (contrib[i])
      );
   end

   pual_reduce #(
      .N (DEPTH),
      .W (LEAF_W)
   ) u_reduce (
      .clock  (clock),
      .leaves (contrib),
      .root   (root)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A valid cursor always points inside the stored part of the list.
   `PUAL_ASSERT_IMPLY(a_cursor_in_list, cursor_valid_ff, cursor_w < count_w, "cursor beyond list end")
   // The list never grows past the chain of cells.
   `PUAL_ASSERT_IMPLY(a_count_bound, 1'b1, count_w <= CW'(DEPTH), "list longer than the chain")
   // An accepted request always starts with the duplicate search.
   `PUAL_ASSERT_NEXT(a_accept_check, req_valid && req_ready, state_ff == pual_pkg::S_CHECK, "accept did not start check")
   // A finished response waits while the previous one is still held.
   `PUAL_ASSERT_NEXT(a_done_holds, (state_ff == pual_pkg::S_DONE) && rsp_valid_ff && !rsp_ready, (state_ff == pual_pkg::S_DONE) && rsp_valid_ff, "pending response overrun")

endmodule
